/* design/mlo_pkg.sv */
// ----------------------------------------------------------------------------
// Mouse-look orientation package
// Widths, reset values, register indexes and the arctangent table shared by
// the mouse-look orientation block.
// ----------------------------------------------------------------------------
package mlo_pkg;

   localparam int CURSOR_W   = 16;
   localparam int DELTA_W    = 17;
   localparam int SENS_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int VEC_W      = 16;
   localparam int YAW_W      = 17;
   localparam int PITCH_W    = 16;
   localparam int MUL_W      = 17;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int WRAP_W     = 31;
   localparam int XY_W       = 32;
   localparam int Z_W        = 26;
   localparam int ATAN_W     = 23;
   localparam int TABLE_LEN  = 20;
   localparam int STEP_W     = 5;
   localparam int REQ_DATA_W = 2 * CURSOR_W;
   localparam int RSP_BITS   = 3 * VEC_W + YAW_W + PITCH_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_W = SENS_W;

   localparam int CORDIC_STEPS_DEFAULT = 14;

   localparam logic [STEP_W-1:0] WRAP_LAST_SHIFT = 5'd11;

   localparam logic [SENS_W-1:0]  SENS_RESET  = 16'd410;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd22784;

   localparam logic CSR_SENSITIVITY = 1'b0;
   localparam logic CSR_PITCH_LIMIT = 1'b1;

   localparam logic signed [XY_W-1:0]   CORDIC_GAIN  = 32'sd163008219;
   localparam logic signed [WRAP_W-1:0] YAW_SPAN     = 31'sd92160;
   localparam logic signed [WRAP_W-1:0] YAW_HALF     = 31'sd46080;
   localparam logic signed [Z_W-1:0]    HALF_TURN    = 26'sd11796480;
   localparam logic signed [Z_W-1:0]    QUARTER_TURN = 26'sd5898240;

   function automatic logic signed [ATAN_W-1:0] atan_deg(input logic [STEP_W-1:0] idx);
      logic signed [ATAN_W-1:0] a;
      case (idx)
         5'd0:    a = 23'sd2949120;
         5'd1:    a = 23'sd1740967;
         5'd2:    a = 23'sd919879;
         5'd3:    a = 23'sd466945;
         5'd4:    a = 23'sd234379;
         5'd5:    a = 23'sd117304;
         5'd6:    a = 23'sd58666;
         5'd7:    a = 23'sd29335;
         5'd8:    a = 23'sd14668;
         5'd9:    a = 23'sd7334;
         5'd10:   a = 23'sd3667;
         5'd11:   a = 23'sd1833;
         5'd12:   a = 23'sd917;
         5'd13:   a = 23'sd458;
         5'd14:   a = 23'sd229;
         5'd15:   a = 23'sd115;
         5'd16:   a = 23'sd57;
         5'd17:   a = 23'sd29;
         5'd18:   a = 23'sd14;
         5'd19:   a = 23'sd7;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [VEC_W-1:0] to_q14(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] r;
      r = (v + 32'sd8192) >>> 14;
      if (r > 32'sd16384) begin
         r = 32'sd16384;
      end else if (r < -32'sd16384) begin
         r = -32'sd16384;
      end
      return VEC_W'(r);
   endfunction

endpackage

/* design/mouse_look_orientation.sv */
// ----------------------------------------------------------------------------
// Mouse-look orientation
// Turns cursor positions into yaw, clamped pitch and a unit view direction,
// using one shared multiplier, a wrap reducer and an iterative CORDIC.
// ----------------------------------------------------------------------------
//  channel  direction  fields (lowest bit first)
//  req      in         cursor_x, cursor_y
//  rsp      out        front_x, front_y, front_z, yaw_angle, pitch_angle
//  csr      in         sensitivity (index 0), pitch_limit (index 1)
//
// A new req transfer is taken only in the idle state, once the previous item
// has finished; each item makes two CORDIC passes through the shared rotation
// datapath after a twelve-step yaw reduction.
// Reset is synchronous and restores the register and accumulator defaults.
// A finished result waits in the output register and does not stop the next
// req transfer; only a second result waiting on a stalled rsp holds the work.
// ----------------------------------------------------------------------------
module mouse_look_orientation
   import mlo_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // cursor_x, cursor_y
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // front_x, front_y, front_z,
                                              // yaw_angle, pitch_angle, zero pad
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ITERS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_PITCH,
      ST_WRAP,
      ST_WRAP_FIX,
      ST_CORDIC_LOAD,
      ST_CORDIC_ITER,
      ST_CORDIC_DONE,
      ST_MUL_FX,
      ST_MUL_FZ,
      ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic                       first_ff, first_in;
   logic signed [CURSOR_W-1:0] prev_x_ff, prev_x_in;
   logic signed [CURSOR_W-1:0] prev_y_ff, prev_y_in;
   logic signed [YAW_W-1:0]    yaw_acc_ff, yaw_acc_in;
   logic signed [PITCH_W-1:0]  pitch_acc_ff, pitch_acc_in;
   logic [SENS_W-1:0]          sens_ff, sens_in;
   logic [LIMIT_W-1:0]         limit_ff, limit_in;
   logic signed [DELTA_W-1:0]  dx_ff, dx_in;
   logic signed [DELTA_W-1:0]  dy_ff, dy_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [WRAP_W-1:0]   wrap_ff, wrap_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [XY_W-1:0]     x_ff, x_in;
   logic signed [XY_W-1:0]     y_ff, y_in;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic                       flip_ff, flip_in;
   logic                       pass_ff, pass_in;
   logic signed [VEC_W-1:0]    sin_yaw_ff, sin_yaw_in;
   logic signed [VEC_W-1:0]    cos_yaw_ff, cos_yaw_in;
   logic signed [VEC_W-1:0]    sin_pitch_ff, sin_pitch_in;
   logic signed [VEC_W-1:0]    cos_pitch_ff, cos_pitch_in;
   logic signed [VEC_W-1:0]    front_x_ff, front_x_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   logic signed [MUL_W-1:0]    mul_a;
   logic signed [MUL_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]   product;
   logic signed [PROD_W-1:0]   move_full;
   logic signed [WRAP_W-1:0]   move_r;
   logic signed [PROD_W-1:0]   prod_q14;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      case (state_ff)
         ST_MUL_Y: begin
            mul_a = dy_ff;
            mul_b = $signed({1'b0, sens_ff});
         end
         ST_MUL_FX: begin
            mul_a = MUL_W'(cos_yaw_ff);
            mul_b = MUL_W'(cos_pitch_ff);
         end
         ST_MUL_FZ: begin
            mul_a = MUL_W'(sin_yaw_ff);
            mul_b = MUL_W'(cos_pitch_ff);
         end
         default: begin
            mul_a = dx_ff;
            mul_b = $signed({1'b0, sens_ff});
         end
      endcase
   end

   assign product   = mul_a * mul_b;
   assign move_full = (prod_ff + 34'sd8) >>> 4;
   assign move_r    = WRAP_W'(move_full);
   assign prod_q14  = (prod_ff + 34'sd8192) >>> 14;

   always_comb begin
      logic signed [CURSOR_W-1:0] cur_x;
      logic signed [CURSOR_W-1:0] cur_y;
      logic signed [WRAP_W-1:0]   pitch_sum;
      logic signed [WRAP_W-1:0]   lim_s;
      logic signed [WRAP_W-1:0]   span_k;
      logic signed [WRAP_W-1:0]   wrap_pos;
      logic signed [Z_W-1:0]      angle;
      logic signed [Z_W-1:0]      atan_z;
      logic signed [XY_W-1:0]     x_out;
      logic signed [XY_W-1:0]     y_out;

      cur_x     = $signed(req_tdata[CURSOR_W-1:0]);
      cur_y     = $signed(req_tdata[REQ_DATA_W-1:CURSOR_W]);
      pitch_sum = WRAP_W'(pitch_acc_ff) + move_r;
      lim_s     = $signed({{(WRAP_W - LIMIT_W){1'b0}}, limit_ff});
      span_k    = YAW_SPAN <<< step_ff;
      wrap_pos  = wrap_ff[WRAP_W-1] ? wrap_ff + YAW_SPAN : wrap_ff;
      angle     = pass_ff ? (Z_W'(pitch_acc_ff) <<< 8) : (Z_W'(yaw_acc_ff) <<< 8);
      atan_z    = Z_W'(atan_deg(step_ff));
      x_out     = flip_ff ? -x_ff : x_ff;
      y_out     = flip_ff ? -y_ff : y_ff;

      state_in     = state_ff;
      first_in     = first_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      yaw_acc_in   = yaw_acc_ff;
      pitch_acc_in = pitch_acc_ff;
      sens_in      = sens_ff;
      limit_in     = limit_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prod_in      = prod_ff;
      wrap_in      = wrap_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      flip_in      = flip_ff;
      pass_in      = pass_ff;
      sin_yaw_in   = sin_yaw_ff;
      cos_yaw_in   = cos_yaw_ff;
      sin_pitch_in = sin_pitch_ff;
      cos_pitch_in = cos_pitch_ff;
      front_x_in   = front_x_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SENSITIVITY: sens_in  = csr_wdata;
            CSR_PITCH_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            default:         sens_in  = sens_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (first_ff) begin
                  dx_in = '0;
                  dy_in = '0;
               end else begin
                  dx_in = DELTA_W'(cur_x) - DELTA_W'(prev_x_ff);
                  dy_in = DELTA_W'(prev_y_ff) - DELTA_W'(cur_y);
               end
               prev_x_in = cur_x;
               prev_y_in = cur_y;
               first_in  = 1'b0;
               state_in  = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            prod_in  = product;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            wrap_in  = WRAP_W'(yaw_acc_ff) + YAW_HALF + move_r;
            prod_in  = product;
            state_in = ST_PITCH;
         end
         ST_PITCH: begin
            if (pitch_sum > lim_s) begin
               pitch_acc_in = PITCH_W'(lim_s);
            end else if (pitch_sum < -lim_s) begin
               pitch_acc_in = PITCH_W'(-lim_s);
            end else begin
               pitch_acc_in = PITCH_W'(pitch_sum);
            end
            step_in  = WRAP_LAST_SHIFT;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (wrap_ff >= span_k) begin
               wrap_in = wrap_ff - span_k;
            end else if (wrap_ff <= -span_k) begin
               wrap_in = wrap_ff + span_k;
            end
            if (step_ff == '0) begin
               state_in = ST_WRAP_FIX;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_WRAP_FIX: begin
            yaw_acc_in = YAW_W'(wrap_pos - YAW_HALF);
            pass_in    = 1'b0;
            state_in   = ST_CORDIC_LOAD;
         end
         ST_CORDIC_LOAD: begin
            if (angle > QUARTER_TURN) begin
               z_in    = angle - HALF_TURN;
               flip_in = 1'b1;
            end else if (angle < -QUARTER_TURN) begin
               z_in    = angle + HALF_TURN;
               flip_in = 1'b1;
            end else begin
               z_in    = angle;
               flip_in = 1'b0;
            end
            x_in     = CORDIC_GAIN;
            y_in     = '0;
            step_in  = '0;
            state_in = ST_CORDIC_ITER;
         end
         ST_CORDIC_ITER: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - (y_ff >>> step_ff);
               y_in = y_ff + (x_ff >>> step_ff);
               z_in = z_ff - atan_z;
            end else begin
               x_in = x_ff + (y_ff >>> step_ff);
               y_in = y_ff - (x_ff >>> step_ff);
               z_in = z_ff + atan_z;
            end
            if (step_ff == LAST_STEP) begin
               state_in = ST_CORDIC_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_CORDIC_DONE: begin
            if (!pass_ff) begin
               cos_yaw_in = to_q14(x_out);
               sin_yaw_in = to_q14(y_out);
               pass_in    = 1'b1;
               state_in   = ST_CORDIC_LOAD;
            end else begin
               cos_pitch_in = to_q14(x_out);
               sin_pitch_in = to_q14(y_out);
               state_in     = ST_MUL_FX;
            end
         end
         ST_MUL_FX: begin
            prod_in  = product;
            state_in = ST_MUL_FZ;
         end
         ST_MUL_FZ: begin
            front_x_in = VEC_W'(prod_q14);
            prod_in    = product;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {{(RSP_DATA_W - RSP_BITS){1'b0}}, pitch_acc_ff, yaw_acc_ff,
                               VEC_W'(prod_q14), sin_pitch_ff, front_x_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      prod_ff      <= prod_in;
      wrap_ff      <= wrap_in;
      step_ff      <= step_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      flip_ff      <= flip_in;
      pass_ff      <= pass_in;
      sin_yaw_ff   <= sin_yaw_in;
      cos_yaw_ff   <= cos_yaw_in;
      sin_pitch_ff <= sin_pitch_in;
      cos_pitch_ff <= cos_pitch_in;
      front_x_ff   <= front_x_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         yaw_acc_ff   <= '0;
         pitch_acc_ff <= '0;
         sens_ff      <= SENS_RESET;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         yaw_acc_ff   <= yaw_acc_in;
         pitch_acc_ff <= pitch_acc_in;
         sens_ff      <= sens_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_busy_after_transfer : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("block still ready in the cycle after a req transfer");

   a_yaw_wrapped : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[64:48]) >= -17'sd46080) &&
                     ($signed(rsp_tdata[64:48]) <= 17'sd46079))
      else $error("yaw angle outside the wrapped range");

   a_front_y_unit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[31:16]) >= -16'sd16384) &&
                     ($signed(rsp_tdata[31:16]) <= 16'sd16384))
      else $error("front_y beyond unit magnitude");

   a_cordic_step_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CORDIC_ITER |-> step_ff <= LAST_STEP)
      else $error("rotation step counter ran past the last step");
`endif

endmodule

/* sim/view_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mouse-look view checker
// Watches the configuration port and both stream channels of the mouse-look
// orientation block. Every req transfer is run through a bit-exact model of
// the yaw and pitch accumulation and of the CORDIC sine and cosine. The
// expected view is queued, and each rsp transfer is compared field by field
// with the oldest queued view.
// ----------------------------------------------------------------------------
module view_checker
   import mlo_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    views_waiting
);

   typedef struct {
      logic signed [VEC_W-1:0]   front_x;
      logic signed [VEC_W-1:0]   front_y;
      logic signed [VEC_W-1:0]   front_z;
      logic signed [YAW_W-1:0]   yaw_angle;
      logic signed [PITCH_W-1:0] pitch_angle;
   } view_type;

   localparam longint GAIN_Q28     = 163008219;
   localparam longint TURN_Q8      = 92160;
   localparam longint HALF_TURN_Q8 = 46080;
   localparam longint HALF_Q16     = 11796480;
   localparam longint QUARTER_Q16  = 5898240;
   localparam int     ANGLE_STEPS  = 20;

   longint angle_step [0:ANGLE_STEPS-1] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
   };

   view_type expected_views [$];
   longint   sensitivity;
   longint   pitch_limit;
   bit       fresh;
   longint   last_x;
   longint   last_y;
   longint   yaw_acc;
   longint   pitch_acc;
   int       result_index;

   function automatic longint round_q(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint to_unit(input longint q28);
      longint r;
      r = round_q(q28, 14);
      if (r > 16384) begin
         r = 16384;
      end else if (r < -16384) begin
         r = -16384;
      end
      return r;
   endfunction

   function automatic void rotate(input longint angle, output longint sin14,
                                  output longint cos14);
      longint x;
      longint y;
      longint z;
      longint nx;
      bit     flip;
      x    = GAIN_Q28;
      y    = 0;
      z    = angle;
      flip = 1'b0;
      if (z > QUARTER_Q16) begin
         z    = z - HALF_Q16;
         flip = 1'b1;
      end else if (z < -QUARTER_Q16) begin
         z    = z + HALF_Q16;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < ANGLE_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - angle_step[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + angle_step[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      sin14 = to_unit(y);
      cos14 = to_unit(x);
   endfunction

   function automatic view_type predict_view(input logic signed [CURSOR_W-1:0] cx,
                                             input logic signed [CURSOR_W-1:0] cy);
      view_type v;
      longint   yaw;
      longint   pitch;
      longint   sin_yaw;
      longint   cos_yaw;
      longint   sin_pitch;
      longint   cos_pitch;
      if (fresh) begin
         fresh  = 1'b0;
         last_x = cx;
         last_y = cy;
      end
      yaw   = yaw_acc + round_q((longint'(cx) - last_x) * sensitivity, 4);
      pitch = pitch_acc + round_q((last_y - longint'(cy)) * sensitivity, 4);
      last_x = cx;
      last_y = cy;
      yaw = ((yaw + HALF_TURN_Q8) % TURN_Q8 + TURN_Q8) % TURN_Q8 - HALF_TURN_Q8;
      if (pitch > pitch_limit) begin
         pitch = pitch_limit;
      end else if (pitch < -pitch_limit) begin
         pitch = -pitch_limit;
      end
      yaw_acc   = yaw;
      pitch_acc = pitch;
      rotate(yaw * 256, sin_yaw, cos_yaw);
      rotate(pitch * 256, sin_pitch, cos_pitch);
      v.front_x     = VEC_W'(round_q(cos_yaw * cos_pitch, 14));
      v.front_y     = VEC_W'(sin_pitch);
      v.front_z     = VEC_W'(round_q(sin_yaw * cos_pitch, 14));
      v.yaw_angle   = YAW_W'(yaw);
      v.pitch_angle = PITCH_W'(pitch);
      return v;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns  view %0d: %s", $time, result_index, what);
      fail_count = fail_count + 1;
   endtask

   task automatic compare_field(input string name, input longint got,
                                input longint want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, %0d was predicted", name, got, want));
      end
   endtask

   always @(posedge clock) begin : watch
      view_type got;
      view_type want;
      if (reset) begin
         sensitivity  = SENS_RESET;
         pitch_limit  = LIMIT_RESET;
         fresh        = 1'b1;
         last_x       = 0;
         last_y       = 0;
         yaw_acc      = 0;
         pitch_acc    = 0;
         result_index = 0;
         expected_views.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SENSITIVITY: sensitivity = csr_wdata;
               CSR_PITCH_LIMIT: pitch_limit = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.front_x     = rsp_tdata[15:0];
            got.front_y     = rsp_tdata[31:16];
            got.front_z     = rsp_tdata[47:32];
            got.yaw_angle   = rsp_tdata[64:48];
            got.pitch_angle = rsp_tdata[80:65];
            if (expected_views.size() == 0) begin
               report_mismatch("transfer arrived with no view outstanding");
            end else begin
               want = expected_views.pop_front();
               compare_field("front_x", got.front_x, want.front_x);
               compare_field("front_y", got.front_y, want.front_y);
               compare_field("front_z", got.front_z, want.front_z);
               compare_field("yaw_angle", got.yaw_angle, want.yaw_angle);
               compare_field("pitch_angle", got.pitch_angle, want.pitch_angle);
            end
            result_index = result_index + 1;
         end
         if (req_tvalid && req_tready) begin
            expected_views.push_back(predict_view(req_tdata[15:0], req_tdata[31:16]));
         end
      end
      views_waiting <= expected_views.size();
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mouse-look orientation testbench
// Drives cursor positions into the block under several sensitivity and pitch
// limit settings, starting with extreme jumps, yaw wrap-around and pitch
// clamping, then mostly small and medium moves mixed with arbitrary jumps.
// Both channels idle at random. A separate checker predicts every view.
// ----------------------------------------------------------------------------
module testbench;
   import mlo_pkg::*;

   localparam int STEPS = CORDIC_STEPS_DEFAULT;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_index = CSR_SENSITIVITY;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int   fail_count;
   int   views_waiting;
   logic calm = 1'b0;
   int   stall_left = 0;
   logic signed [CURSOR_W-1:0] pos_x = '0;
   logic signed [CURSOR_W-1:0] pos_y = '0;

   always #5 clock = ~clock;

   mouse_look_orientation #(
      .CORDIC_STEPS(STEPS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   view_checker #(
      .CORDIC_STEPS(STEPS)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .views_waiting (views_waiting)
   );

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(15, 60);
   endfunction

   always @(negedge clock) begin : view_sink
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         g = idle_length();
         rsp_tready <= (g == 0);
         if (g != 0) begin
            stall_left <= g - 1;
         end
      end
   end

   // Called and left at a falling edge; the valid is only lowered when a gap
   // follows, so back-to-back transfers keep it high.
   task automatic send_position(input int x, input int y);
      int gap;
      pos_x = CURSOR_W'(x);
      pos_y = CURSOR_W'(y);
      req_tvalid <= 1'b1;
      req_tdata  <= {pos_y, pos_x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      gap = calm ? 0 : idle_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_random(input int count);
      int kind;
      int nx;
      int ny;
      repeat (count) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            nx = pos_x + $urandom_range(0, 40) - 20;
            ny = pos_y + $urandom_range(0, 40) - 20;
         end else if (kind < 80) begin
            nx = pos_x + $urandom_range(0, 4000) - 2000;
            ny = pos_y + $urandom_range(0, 4000) - 2000;
         end else if (kind < 88) begin
            nx = pos_x;
            ny = pos_y;
         end else begin
            nx = $urandom_range(0, 65535);
            ny = $urandom_range(0, 65535);
         end
         if ($urandom_range(0, 39) == 0) begin
            calm <= ~calm;
         end
         send_position(nx, ny);
      end
   endtask

   task automatic set_config(input int sens, input int limit);
      req_tvalid <= 1'b0;
      while (views_waiting != 0) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SENSITIVITY;
      csr_wdata <= CSR_DATA_W'(sens);
      @(negedge clock);
      csr_index <= CSR_PITCH_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The first position only sets the reference, so it yields no movement.
      send_position(32767, -32768);
      send_position(32767, -32768);
      send_position(-32768, 32767);
      send_position(32767, -32768);
      send_position(0, 0);
      send_position(1, -1);
      send_position(0, 0);
      send_position(-1, 1);
      send_position(900, 0);
      send_position(1800, 0);
      send_position(2700, 0);
      send_position(3600, 0);
      send_position(4500, 0);
      send_position(4500, -880);
      send_position(4500, -900);
      send_position(4500, 1800);
      send_position(16384, -16384);
      send_position(-16384, 16384);
      send_position(-1, -1);
      send_random(60);

      set_config(65535, LIMIT_RESET);
      send_random(50);
      // A lowered limit clamps the pitch already reached on the next transfer.
      set_config(0, 0);
      send_random(30);
      set_config(1, 32767);
      send_random(50);
      set_config(4096, 8000);
      send_random(50);
      repeat (3) begin
         set_config($urandom_range(0, 65535), $urandom_range(0, 32767));
         send_random(40);
      end
      set_config(SENS_RESET, LIMIT_RESET);
      send_random(40);

      req_tvalid <= 1'b0;
      calm <= 1'b0;
      while (views_waiting != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0 && views_waiting == 0) begin
         $display("mouse_look_orientation: match");
      end else begin
         $display("mouse_look_orientation: mismatch");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("mouse_look_orientation: mismatch");
      $finish;
   end

endmodule
